@@ sv/efms_pkg.sv @@
// Shared constants and types of the earliest-free-machine scheduler.
`default_nettype none

package efms_pkg;

    localparam int MAX_MACHINES = 1024;
    localparam int TIME_W       = 32;
    localparam int CFG_W        = 11;
    localparam int EPOCH_W      = 8;

    typedef logic [TIME_W-1:0] tick_t;
    typedef logic [CFG_W-1:0]  cfg_word_t;

endpackage

`default_nettype wire

@@ sv/efms_task_if.sv @@
// Task channel: release time, duration and end-of-batch mark.
`default_nettype none

interface efms_task_if;

    logic            valid;
    logic            ready;
    efms_pkg::tick_t release_time;
    efms_pkg::tick_t duration;
    logic            last_of_batch;

    modport source (
        output valid,
        output release_time,
        output duration,
        output last_of_batch,
        input  ready
    );

    modport sink (
        input  valid,
        input  release_time,
        input  duration,
        input  last_of_batch,
        output ready
    );

endinterface

`default_nettype wire

@@ sv/efms_result_if.sv @@
// Result channel: finish time, makespan and saturation flag.
`default_nettype none

interface efms_result_if;

    logic            valid;
    logic            ready;
    efms_pkg::tick_t finish_time;
    efms_pkg::tick_t makespan;
    logic            saturated;

    modport source (
        output valid,
        output finish_time,
        output makespan,
        output saturated,
        input  ready
    );

    modport sink (
        input  valid,
        input  finish_time,
        input  makespan,
        input  saturated,
        output ready
    );

endinterface

`default_nettype wire

@@ sv/earliest_free_machine_scheduler_unit.sv @@
// Top level: greedy list scheduler over a min-heap of machine free times in block RAM.
//
// Each task word takes the earliest machine free time from the heap root, computes
// finish = max(release_time, root) + duration (clamped to all ones, flagged in
// saturated), puts the finish time back at the root and sifts it down. The heap
// sits in one RAM with two registered read ports and one write port. A task word
// is taken in ST_IDLE and its finish time formed in ST_FIN; every level of the
// sift has a read state (ST_SIFT_RD) and a compare/write state (ST_SIFT_CMP), and
// the sift stops where the entry has no child (one machine, or at a leaf) or no
// smaller child. ST_DONE loads the result and returns to ST_IDLE for the next
// word. One task is in flight at a time; a finished result waits in the output
// register while the next task is taken. Clearing the
// heap (writing machine_count, or after a word marked last_of_batch) bumps an
// 8-bit epoch tag kept with every entry, so a clear is free; after reset, and on
// every 255th clear, the tags wrap and a sweep of all MAX_MACHINES words rewrites
// the RAM while task_in.ready stays low. machine_count of 0 acts as 1, above
// MAX_MACHINES as MAX_MACHINES.
`default_nettype none

module earliest_free_machine_scheduler_unit #(
    parameter int MAX_MACHINES = efms_pkg::MAX_MACHINES
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire efms_pkg::cfg_word_t  cfg_wdata,
    efms_task_if.sink                 task_in,
    efms_result_if.source             result_out
);

    localparam int ADDR_W  = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int IDX_W   = ADDR_W + 2;
    localparam int TIME_W  = efms_pkg::TIME_W;
    localparam int EPOCH_W = efms_pkg::EPOCH_W;
    localparam int MEM_W   = EPOCH_W + TIME_W;

    typedef enum logic [5:0] {
        ST_SWEEP    = 6'b000001,
        ST_IDLE     = 6'b000010,
        ST_FIN      = 6'b000100,
        ST_SIFT_RD  = 6'b001000,
        ST_SIFT_CMP = 6'b010000,
        ST_DONE     = 6'b100000
    } state_t;

    typedef logic [EPOCH_W-1:0] epoch_t;

    logic [MEM_W-1:0] heap_mem [MAX_MACHINES];

    state_t              state_reg, state_next;
    epoch_t              epoch_reg, epoch_next;
    logic [ADDR_W-1:0]   sweep_reg, sweep_next;
    logic [IDX_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                r_ok_reg, r_ok_next;
    efms_pkg::tick_t     release_reg, release_next;
    efms_pkg::tick_t     duration_reg, duration_next;
    logic                last_reg, last_next;
    efms_pkg::tick_t     finish_reg, finish_next;
    logic                sat_reg, sat_next;
    efms_pkg::tick_t     makespan_reg, makespan_next;
    logic                out_valid_reg, out_valid_next;
    efms_pkg::tick_t     out_finish_reg, out_finish_next;
    efms_pkg::tick_t     out_makespan_reg, out_makespan_next;
    logic                out_sat_reg, out_sat_next;

    logic [MEM_W-1:0]    rd_a_reg, rd_b_reg;
    logic [ADDR_W-1:0]   addr_a, addr_b, mem_waddr;
    logic [MEM_W-1:0]    mem_wdata;
    logic                mem_we;

    efms_pkg::tick_t     a_val, b_val, child_val, start_val, ms_new;
    logic [TIME_W:0]     sum;
    logic [IDX_W-1:0]    left_idx, right_idx, cfg_count;
    logic                pick_r, accept, load_out, clear_req;

    assign accept   = task_in.valid && task_in.ready;
    assign task_in.ready = (state_reg == ST_IDLE);

    assign left_idx  = (idx_reg << 1) + IDX_W'(1);
    assign right_idx = left_idx + IDX_W'(1);

    assign a_val = (rd_a_reg[MEM_W-1:TIME_W] == epoch_reg) ? rd_a_reg[TIME_W-1:0] : '0;
    assign b_val = (rd_b_reg[MEM_W-1:TIME_W] == epoch_reg) ? rd_b_reg[TIME_W-1:0] : '0;

    assign pick_r    = r_ok_reg && (b_val < a_val);
    assign child_val = pick_r ? b_val : a_val;

    assign start_val = (a_val > release_reg) ? a_val : release_reg;
    assign sum       = {1'b0, start_val} + {1'b0, duration_reg};
    assign ms_new    = (finish_reg > makespan_reg) ? finish_reg : makespan_reg;

    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || result_out.ready);
    assign clear_req = cfg_we || (load_out && last_reg);

    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            cfg_count = IDX_W'(1);
        end
        else if (32'(cfg_wdata) > 32'(MAX_MACHINES))
        begin
            cfg_count = IDX_W'(MAX_MACHINES);
        end
        else
        begin
            cfg_count = IDX_W'(cfg_wdata);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heap_mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= heap_mem[addr_a];
        rd_b_reg <= heap_mem[addr_b];
    end

    always_comb
    begin
        state_next        = state_reg;
        epoch_next        = epoch_reg;
        sweep_next        = sweep_reg;
        count_next        = cfg_we ? cfg_count : count_reg;
        idx_next          = idx_reg;
        r_ok_next         = r_ok_reg;
        release_next      = release_reg;
        duration_next     = duration_reg;
        last_next         = last_reg;
        finish_next       = finish_reg;
        sat_next          = sat_reg;
        makespan_next     = makespan_reg;
        out_valid_next    = out_valid_reg;
        out_finish_next   = out_finish_reg;
        out_makespan_next = out_makespan_reg;
        out_sat_next      = out_sat_reg;
        addr_a            = '0;
        addr_b            = '0;
        mem_we            = 1'b0;
        mem_waddr         = idx_reg[ADDR_W-1:0];
        mem_wdata         = {epoch_reg, finish_reg};

        if (out_valid_reg && result_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                mem_wdata = '0;
                if (sweep_reg == ADDR_W'(MAX_MACHINES - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + ADDR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    release_next  = task_in.release_time;
                    duration_next = task_in.duration;
                    last_next     = task_in.last_of_batch;
                    state_next    = ST_FIN;
                end
            end
            ST_FIN:
            begin
                sat_next    = sum[TIME_W];
                finish_next = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                idx_next    = '0;
                state_next  = ST_SIFT_RD;
            end
            ST_SIFT_RD:
            begin
                addr_a    = left_idx[ADDR_W-1:0];
                addr_b    = right_idx[ADDR_W-1:0];
                r_ok_next = right_idx < count_reg;
                if (left_idx >= count_reg)
                begin
                    mem_we     = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SIFT_CMP;
                end
            end
            ST_SIFT_CMP:
            begin
                mem_we = 1'b1;
                if (finish_reg <= child_val)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_wdata  = {epoch_reg, child_val};
                    idx_next   = pick_r ? right_idx : left_idx;
                    state_next = ST_SIFT_RD;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next    = 1'b1;
                    out_finish_next   = finish_reg;
                    out_makespan_next = ms_new;
                    out_sat_next      = sat_reg;
                    makespan_next     = ms_new;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_SWEEP;
                sweep_next = '0;
            end
        endcase

        // clear: new epoch, or a full sweep when the tag wraps
        if (clear_req)
        begin
            makespan_next = '0;
            if (state_reg != ST_SWEEP)
            begin
                if (epoch_reg == '1)
                begin
                    epoch_next = epoch_t'(1);
                    sweep_next = '0;
                    state_next = ST_SWEEP;
                end
                else
                begin
                    epoch_next = epoch_reg + epoch_t'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            epoch_reg     <= epoch_t'(1);
            sweep_reg     <= '0;
            count_reg     <= IDX_W'(1);
            makespan_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            epoch_reg     <= epoch_next;
            sweep_reg     <= sweep_next;
            count_reg     <= count_next;
            makespan_reg  <= makespan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg          <= idx_next;
        r_ok_reg         <= r_ok_next;
        release_reg      <= release_next;
        duration_reg     <= duration_next;
        last_reg         <= last_next;
        finish_reg       <= finish_next;
        sat_reg          <= sat_next;
        out_finish_reg   <= out_finish_next;
        out_makespan_reg <= out_makespan_next;
        out_sat_reg      <= out_sat_next;
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.finish_time = out_finish_reg;
    assign result_out.makespan    = out_makespan_reg;
    assign result_out.saturated   = out_sat_reg;

    a_accept_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_FIN)
        else $error("accepted task did not start");

    a_makespan_covers_finish: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_makespan_reg >= out_finish_reg)
        else $error("makespan below finish time");

    a_sat_clamps: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_sat_reg |-> out_finish_reg == '1)
        else $error("saturated result not clamped");

    a_heap_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && state_reg != ST_SWEEP |-> idx_reg < count_reg)
        else $error("heap write beyond machine count");

    a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_reg != '0)
        else $error("epoch tag collides with swept tag");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Testbench for the scheduler: random and directed task words checked against a heap predictor.

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_HALF     = 6;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned SWEEP_WAIT   = 2 * efms_pkg::MAX_MACHINES + 16;

    typedef struct packed {
        efms_pkg::tick_t finish_time;
        efms_pkg::tick_t makespan;
        logic            saturated;
    } sched_result_t;

    class sched_scoreboard;
        efms_pkg::tick_t free_at [efms_pkg::MAX_MACHINES];
        efms_pkg::tick_t span;
        int unsigned     machines;
        sched_result_t   due_q [$];
        int unsigned     mismatches;
        int unsigned     compared;
        int unsigned     saturations;

        function new();
            machines    = 1;
            mismatches  = 0;
            compared    = 0;
            saturations = 0;
            clear_batch();
        endfunction

        function void clear_batch();
            foreach (free_at[i])
                free_at[i] = '0;
            span = '0;
        endfunction

        function void set_machine_count(efms_pkg::cfg_word_t v);
            if (v == 0)
                machines = 1;
            else if (v > efms_pkg::MAX_MACHINES)
                machines = efms_pkg::MAX_MACHINES;
            else
                machines = v;
            clear_batch();
        endfunction

        function int unsigned pending();
            return due_q.size();
        endfunction

        // Replace the heap root with the new finish time and sift it down.
        function void note_task(efms_pkg::tick_t rel, efms_pkg::tick_t dur, logic last);
            efms_pkg::tick_t start;
            efms_pkg::tick_t tmp;
            logic [32:0]     total;
            sched_result_t   r;
            int unsigned     i;
            int unsigned     l;
            int unsigned     c;
            bit              done;
            start = (rel > free_at[0]) ? rel : free_at[0];
            total = {1'b0, start} + {1'b0, dur};
            r.saturated   = total[32];
            r.finish_time = total[32] ? '1 : total[31:0];
            if (r.saturated)
                saturations++;
            if (r.finish_time > span)
                span = r.finish_time;
            r.makespan = span;
            free_at[0] = r.finish_time;
            i    = 0;
            done = 1'b0;
            while (!done)
            begin
                l = 2 * i + 1;
                if (l >= machines)
                begin
                    done = 1'b1;
                end
                else
                begin
                    c = l;
                    if (l + 1 < machines && free_at[l + 1] < free_at[l])
                        c = l + 1;
                    if (free_at[i] <= free_at[c])
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        tmp        = free_at[i];
                        free_at[i] = free_at[c];
                        free_at[c] = tmp;
                        i          = c;
                    end
                end
            end
            due_q.push_back(r);
            if (last)
                clear_batch();
        endfunction

        function void check_result(efms_pkg::tick_t finish, efms_pkg::tick_t mk, logic sat);
            sched_result_t want;
            if (due_q.size() == 0)
            begin
                $display("%0t: result word with nothing due: finish_time=%h makespan=%h sat=%b",
                         $realtime, finish, mk, sat);
                mismatches++;
                return;
            end
            want = due_q.pop_front();
            compared++;
            if (finish !== want.finish_time)
            begin
                $display("%0t: finish_time expected %h got %h",
                         $realtime, want.finish_time, finish);
                mismatches++;
            end
            if (mk !== want.makespan)
            begin
                $display("%0t: makespan expected %h got %h", $realtime, want.makespan, mk);
                mismatches++;
            end
            if (sat !== want.saturated)
            begin
                $display("%0t: saturated expected %b got %b", $realtime, want.saturated, sat);
                mismatches++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    efms_pkg::cfg_word_t cfg_wdata;

    efms_task_if   task_if ();
    efms_result_if result_if ();

    sched_scoreboard sb = new();

    int unsigned sender_idle_pct;
    int unsigned receiver_idle_pct;
    int unsigned hold_left;
    int unsigned words_sent;
    int unsigned batch_clears;
    int unsigned cfg_writes;

    earliest_free_machine_scheduler_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .task_in    (task_if),
        .result_out (result_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("tb_top: FAIL");
        $finish;
    end

    // Result side: check accepted words, then pick ready for the next edge.
    initial
    begin
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_if.valid && result_if.ready)
                sb.check_result(result_if.finish_time, result_if.makespan,
                                result_if.saturated);
            if (hold_left > 0)
            begin
                result_if.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                result_if.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            end
        end
    end

    task automatic send_task(input efms_pkg::tick_t rel, input efms_pkg::tick_t dur,
                             input logic last);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            task_if.valid <= 1'b0;
            @(posedge clk);
        end
        task_if.valid         <= 1'b1;
        task_if.release_time  <= rel;
        task_if.duration      <= dur;
        task_if.last_of_batch <= last;
        @(posedge clk);
        while (!task_if.ready)
            @(posedge clk);
        sb.note_task(rel, dur, last);
        words_sent++;
        if (last)
            batch_clears++;
    endtask

    // Only written with nothing in flight; a clearing sweep may still hold ready low.
    task automatic write_machine_count(input efms_pkg::cfg_word_t v);
        int unsigned n;
        task_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        n = 0;
        while (!task_if.ready && n < SWEEP_WAIT)
        begin
            @(posedge clk);
            n++;
        end
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_machine_count(v);
        cfg_writes++;
    endtask

    function automatic efms_pkg::tick_t pick_duration();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            3:       return '1 - $urandom_range(0, 255);
            4, 5:    return $urandom_range(0, 1 << 20);
            default: return $urandom_range(1, 1000);
        endcase
    endfunction

    // Mostly near the current schedule so that release and root both win.
    function automatic efms_pkg::tick_t pick_release();
        case ($urandom_range(0, 15))
            0:                return '0;
            1:                return '1;
            2:                return $urandom;
            3:                return '1 - $urandom_range(0, 255);
            4, 5, 6, 7, 8, 9: return sb.span + $urandom_range(0, 500);
            default:          return $urandom_range(0, sb.span);
        endcase
    endfunction

    task automatic run_segment(input efms_pkg::cfg_word_t count, input int unsigned items,
                               input int unsigned max_batch, input int unsigned hold);
        int unsigned left;
        int unsigned batch;
        int unsigned k;
        logic        last;
        write_machine_count(count);
        if (hold != 0)
            hold_left = hold;
        left = items;
        while (left > 0)
        begin
            batch = $urandom_range(1, max_batch);
            if (batch > left)
                batch = left;
            for (k = 1; k <= batch; k++)
            begin
                last = (k == batch);
                if ($urandom_range(0, 19) == 0)
                    last = ~last;
                send_task(pick_release(), pick_duration(), last);
            end
            left -= batch;
        end
    endtask

    task automatic directed_tests();
        // one machine from reset
        send_task(32'd0, 32'd0, 1'b0);
        send_task(32'd5, 32'd10, 1'b0);
        send_task(32'd0, 32'd3, 1'b0);
        send_task('1, 32'd0, 1'b0);
        send_task(32'd1, '1, 1'b1);
        // zero acts as one
        write_machine_count(11'd0);
        send_task('1, '1, 1'b0);
        send_task(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        // write mid-batch clears, then equal free times exercise tie-break
        write_machine_count(11'd3);
        send_task(32'd0, 32'd7, 1'b0);
        send_task(32'd0, 32'd7, 1'b0);
        send_task(32'd0, 32'd7, 1'b0);
        send_task(32'd0, 32'd7, 1'b0);
        send_task(32'd2, 32'd5, 1'b0);
        send_task(32'd0, 32'd1, 1'b0);
        send_task(32'd20, 32'd0, 1'b1);
        // above the maximum acts as the maximum
        write_machine_count(11'h7FF);
        send_task(32'd10, 32'd20, 1'b0);
        send_task(32'd0, 32'd0, 1'b0);
        send_task(32'hFFFF_FFFE, 32'd1, 1'b0);
        send_task(32'd3, 32'd4, 1'b1);
    endtask

    initial
    begin
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_wdata             <= '0;
        task_if.valid         <= 1'b0;
        task_if.release_time  <= '0;
        task_if.duration      <= '0;
        task_if.last_of_batch <= 1'b0;
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_left         = 0;
        words_sent        = 0;
        batch_clears      = 0;
        cfg_writes        = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_tests();

        sender_idle_pct   = 19;
        receiver_idle_pct = 85;
        run_segment(11'd2, 35, 8, 0);
        run_segment(11'd5, 35, 17, 0);
        run_segment(11'd2047, 25, 40, 0);
        run_segment(11'd16, 30, 48, 0);

        sender_idle_pct   = 85;
        receiver_idle_pct = 19;
        run_segment(11'd3, 35, 11, 0);
        run_segment(11'd1, 40, 2, 0);
        run_segment(11'd1024, 20, 48, 0);
        run_segment(11'd7, 35, 23, 0);

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_segment(11'd4, 30, 14, HOLD_CYCLES);
        // single-word batches: enough clears to wrap the epoch tags
        run_segment(11'd2, 220, 1, 0);
        run_segment(11'd1025, 12, 48, 0);
        run_segment(11'd12, 20, 38, 0);

        task_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb_top: %0d task words, %0d results compared, %0d saturated finish times",
                 words_sent, sb.compared, sb.saturations);
        $display("tb_top: %0d batch ends, %0d machine_count writes from 0 to 2047",
                 batch_clears, cfg_writes);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
